// File: src/thxz_pkg.sv
// ----------------------------------------------------------------------------
// thxz_pkg: shared definitions for the triangle height block
// Payload widths, beat mode codes, tolerance constants and the side-band
// record that travels with each query through the pipeline.
// ----------------------------------------------------------------------------
package thxz_pkg;

  localparam int PORT_COORD_W = 32;
  localparam int SLOT_W       = 8;

  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Tolerance of 1e-5 on s and t, written as ratios over TOL_K.
  localparam int TOL_K  = 100000;
  localparam int TOL_K1 = 100001;
  localparam int TOL_W  = 18;

  // valid marks a query beat in the stage; kill forces an outside result.
  typedef struct packed {
    logic valid;
    logic kill;
  } ctl_t;

endpackage

// File: src/thxz_in_if.sv
// ----------------------------------------------------------------------------
// thxz_in_if: input channel
// Carries vertex writes and height queries with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface thxz_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     mode;
  logic        [thxz_pkg::SLOT_W-1:0]       vertex_slot;
  logic signed [thxz_pkg::PORT_COORD_W-1:0] vertex_x;
  logic signed [thxz_pkg::PORT_COORD_W-1:0] vertex_y;
  logic signed [thxz_pkg::PORT_COORD_W-1:0] vertex_z;
  logic        [thxz_pkg::SLOT_W-1:0]       first_edge_start;
  logic        [thxz_pkg::SLOT_W-1:0]       first_edge_end;
  logic        [thxz_pkg::SLOT_W-1:0]       second_edge_start;
  logic        [thxz_pkg::SLOT_W-1:0]       second_edge_end;
  logic signed [thxz_pkg::PORT_COORD_W-1:0] query_x;
  logic signed [thxz_pkg::PORT_COORD_W-1:0] query_z;

  modport source (
    output valid, mode, vertex_slot, vertex_x, vertex_y, vertex_z,
           first_edge_start, first_edge_end, second_edge_start, second_edge_end,
           query_x, query_z,
    input  ready
  );
  modport sink (
    input  valid, mode, vertex_slot, vertex_x, vertex_y, vertex_z,
           first_edge_start, first_edge_end, second_edge_start, second_edge_end,
           query_x, query_z,
    output ready
  );
endinterface

// File: src/thxz_out_if.sv
// ----------------------------------------------------------------------------
// thxz_out_if: result channel
// Carries the inside flag and interpolated height with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface thxz_out_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     inside_res;
  logic signed [thxz_pkg::PORT_COORD_W-1:0] height;

  modport source (output valid, inside_res, height, input ready);
  modport sink (input valid, inside_res, height, output ready);
endinterface

// File: src/thxz_vstore.sv
// ----------------------------------------------------------------------------
// thxz_vstore: vertex store
// Three copies of the vertex memory, written together, each read at one
// corner address per advancing cycle, with registered read data.
// ----------------------------------------------------------------------------
module thxz_vstore #(
  parameter int VERTEX_DEPTH = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic                            clk,
  input  logic                            adv,
  input  logic                            we,
  input  logic [$clog2(VERTEX_DEPTH)-1:0] waddr,
  input  logic [3*COORD_BITS-1:0]         wdata,
  input  logic [$clog2(VERTEX_DEPTH)-1:0] raddr_a,
  input  logic [$clog2(VERTEX_DEPTH)-1:0] raddr_b,
  input  logic [$clog2(VERTEX_DEPTH)-1:0] raddr_c,
  output logic [3*COORD_BITS-1:0]         rdata_a,
  output logic [3*COORD_BITS-1:0]         rdata_b,
  output logic [3*COORD_BITS-1:0]         rdata_c
);

  localparam int VW = 3 * COORD_BITS;

  logic [VW-1:0] mem_a [0:VERTEX_DEPTH-1];
  logic [VW-1:0] mem_b [0:VERTEX_DEPTH-1];
  logic [VW-1:0] mem_c [0:VERTEX_DEPTH-1];
  logic [VW-1:0] rd_a_r, rd_b_r, rd_c_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_a[waddr] <= wdata;
      mem_b[waddr] <= wdata;
      mem_c[waddr] <= wdata;
    end
  end

  // Read data holds while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      rd_a_r <= mem_a[raddr_a];
      rd_b_r <= mem_b[raddr_b];
      rd_c_r <= mem_c[raddr_c];
    end
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;
  assign rdata_c = rd_c_r;

endmodule

// File: src/thxz_geom.sv
// ----------------------------------------------------------------------------
// thxz_geom: barycentric front end
// Edge vectors, cross products, orientation fix, tolerance test and the
// height numerator, over eight register stages.
// ----------------------------------------------------------------------------
module thxz_geom #(
  parameter int COORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  thxz_pkg::ctl_t                    in_ctl,
  input  logic signed [COORD_BITS-1:0]      ax, ay, az,
  input  logic signed [COORD_BITS-1:0]      bx, by, bz,
  input  logic signed [COORD_BITS-1:0]      cx, cy, cz,
  input  logic signed [COORD_BITS-1:0]      qx, qz,
  output thxz_pkg::ctl_t                    out_ctl,
  output logic [3*COORD_BITS+5-1:0]         num_abs,
  output logic                              num_neg,
  output logic [2*COORD_BITS+2-1:0]         den,
  output logic signed [COORD_BITS-1:0]      ay_out
);

  localparam int C    = COORD_BITS;
  localparam int EW   = C + 1;
  localparam int PW   = 2 * EW;
  localparam int CW   = PW + 1;
  localparam int KW   = thxz_pkg::TOL_W;
  localparam int TW   = CW + 1 + KW;
  localparam int LB   = CW / 2;
  localparam int PLW  = LB + 1 + EW;
  localparam int PHW  = CW - LB + EW;
  localparam int NUMW = CW + EW + 1;
  localparam int DW   = CW - 1;

  localparam logic signed [KW-1:0] K_S  = KW'(thxz_pkg::TOL_K);
  localparam logic signed [KW-1:0] K1_S = KW'(thxz_pkg::TOL_K1);

  thxz_pkg::ctl_t c1_r, c2_r, c3_r, c4_r, c5_r, c6_r, c7_r, c8_r;
  thxz_pkg::ctl_t c4_nxt, c6_nxt;

  // Stage 1: edge vectors.
  logic signed [EW-1:0] e1x_r, e1z_r, e2x_r, e2z_r, e0x_r, e0z_r, e1y_r, e2y_r;
  logic signed [C-1:0]  ay1_r;
  // Stage 2: products.
  logic signed [PW-1:0] md1_r, md2_r, ms1_r, ms2_r, mt1_r, mt2_r;
  logic signed [EW-1:0] e1y2_r, e2y2_r;
  logic signed [C-1:0]  ay2_r;
  // Stage 3: cross products.
  logic signed [CW-1:0] d3_r, ns3_r, nt3_r;
  logic signed [EW-1:0] e1y3_r, e2y3_r;
  logic signed [C-1:0]  ay3_r;
  // Stage 4: orientation fixed so that the denominator is positive.
  logic signed [CW-1:0] d4_r, ns4_r, nt4_r, d4_nxt, ns4_nxt, nt4_nxt;
  logic signed [EW-1:0] e1y4_r, e2y4_r;
  logic signed [C-1:0]  ay4_r;
  // Stage 5: tolerance products and numerator partial products.
  logic signed [TW-1:0]  kp_r, kt_r, dk_r;
  logic signed [PLW-1:0] pl1_r, pl2_r;
  logic signed [PHW-1:0] ph1_r, ph2_r;
  logic signed [CW-1:0]  d5_r;
  logic signed [C-1:0]   ay5_r;
  // Stage 6: tolerance decision and the two full products.
  logic signed [NUMW-1:0] p1_r, p2_r;
  logic signed [CW-1:0]   d6_r;
  logic signed [C-1:0]    ay6_r;
  logic signed [TW-1:0]   d5_t, sum_p, sum_t, sum_st;
  logic                   reject;
  // Stage 7: numerator.
  logic signed [NUMW-1:0] num7_r;
  logic signed [CW-1:0]   d7_r;
  logic signed [C-1:0]    ay7_r;
  // Stage 8: magnitude and sign.
  logic [NUMW-1:0]     abs8_r;
  logic                neg8_r;
  logic [DW-1:0]       d8_r;
  logic signed [C-1:0] ay8_r;

  always_comb begin
    c4_nxt = c3_r;
    if (d3_r == '0) begin
      c4_nxt.kill = 1'b1;
    end
    if (d3_r[CW-1]) begin
      d4_nxt  = -d3_r;
      ns4_nxt = -ns3_r;
      nt4_nxt = -nt3_r;
    end else begin
      d4_nxt  = d3_r;
      ns4_nxt = ns3_r;
      nt4_nxt = nt3_r;
    end
  end

  // Rejected when s or t is below -1e-5, above 1.00001, or s + t above 1.00001.
  always_comb begin
    d5_t   = TW'(d5_r);
    sum_p  = kp_r + d5_t;
    sum_t  = kt_r + d5_t;
    sum_st = kp_r + kt_r;
    reject = sum_p[TW-1] || sum_t[TW-1] || (dk_r < kp_r) || (dk_r < kt_r) ||
             (dk_r < sum_st);
    c6_nxt = c5_r;
    if (reject) begin
      c6_nxt.kill = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
      c2_r <= '0;
      c3_r <= '0;
      c4_r <= '0;
      c5_r <= '0;
      c6_r <= '0;
      c7_r <= '0;
      c8_r <= '0;
    end else if (adv) begin
      c1_r <= in_ctl;
      c2_r <= c1_r;
      c3_r <= c2_r;
      c4_r <= c4_nxt;
      c5_r <= c4_r;
      c6_r <= c6_nxt;
      c7_r <= c6_r;
      c8_r <= c7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1x_r  <= EW'(bx) - EW'(ax);
      e1z_r  <= EW'(bz) - EW'(az);
      e2x_r  <= EW'(cx) - EW'(ax);
      e2z_r  <= EW'(cz) - EW'(az);
      e0x_r  <= EW'(qx) - EW'(ax);
      e0z_r  <= EW'(qz) - EW'(az);
      e1y_r  <= EW'(by) - EW'(ay);
      e2y_r  <= EW'(cy) - EW'(ay);
      ay1_r  <= ay;

      md1_r  <= PW'(e1x_r) * PW'(e2z_r);
      md2_r  <= PW'(e1z_r) * PW'(e2x_r);
      ms1_r  <= PW'(e0x_r) * PW'(e2z_r);
      ms2_r  <= PW'(e0z_r) * PW'(e2x_r);
      mt1_r  <= PW'(e1x_r) * PW'(e0z_r);
      mt2_r  <= PW'(e1z_r) * PW'(e0x_r);
      e1y2_r <= e1y_r;
      e2y2_r <= e2y_r;
      ay2_r  <= ay1_r;

      d3_r   <= CW'(md1_r) - CW'(md2_r);
      ns3_r  <= CW'(ms1_r) - CW'(ms2_r);
      nt3_r  <= CW'(mt1_r) - CW'(mt2_r);
      e1y3_r <= e1y2_r;
      e2y3_r <= e2y2_r;
      ay3_r  <= ay2_r;

      d4_r   <= d4_nxt;
      ns4_r  <= ns4_nxt;
      nt4_r  <= nt4_nxt;
      e1y4_r <= e1y3_r;
      e2y4_r <= e2y3_r;
      ay4_r  <= ay3_r;

      kp_r   <= TW'(ns4_r) * TW'(K_S);
      kt_r   <= TW'(nt4_r) * TW'(K_S);
      dk_r   <= TW'(d4_r) * TW'(K1_S);
      pl1_r  <= PLW'(signed'({1'b0, ns4_r[LB-1:0]})) * PLW'(e1y4_r);
      ph1_r  <= PHW'(signed'(ns4_r[CW-1:LB])) * PHW'(e1y4_r);
      pl2_r  <= PLW'(signed'({1'b0, nt4_r[LB-1:0]})) * PLW'(e2y4_r);
      ph2_r  <= PHW'(signed'(nt4_r[CW-1:LB])) * PHW'(e2y4_r);
      d5_r   <= d4_r;
      ay5_r  <= ay4_r;

      p1_r   <= (NUMW'(ph1_r) <<< LB) + NUMW'(pl1_r);
      p2_r   <= (NUMW'(ph2_r) <<< LB) + NUMW'(pl2_r);
      d6_r   <= d5_r;
      ay6_r  <= ay5_r;

      num7_r <= p1_r + p2_r;
      d7_r   <= d6_r;
      ay7_r  <= ay6_r;

      neg8_r <= num7_r[NUMW-1];
      abs8_r <= num7_r[NUMW-1] ? NUMW'(-num7_r) : NUMW'(num7_r);
      d8_r   <= d7_r[DW-1:0];
      ay8_r  <= ay7_r;
    end
  end

  assign out_ctl = c8_r;
  assign num_abs = abs8_r;
  assign num_neg = neg8_r;
  assign den     = d8_r;
  assign ay_out  = ay8_r;

endmodule

// File: src/thxz_div.sv
// ----------------------------------------------------------------------------
// thxz_div: pipelined divider and height output
// One restoring quotient bit per stage, round to nearest, then signed add of
// the base height with saturation into the result register.
// ----------------------------------------------------------------------------
module thxz_div #(
  parameter int COORD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  adv,
  input  thxz_pkg::ctl_t                        in_ctl,
  input  logic [3*COORD_BITS+5-1:0]             num_abs,
  input  logic                                  num_neg,
  input  logic [2*COORD_BITS+2-1:0]             den,
  input  logic signed [COORD_BITS-1:0]          ay,
  output thxz_pkg::ctl_t                        res_ctl,
  output logic                                  res_inside,
  output logic signed [thxz_pkg::PORT_COORD_W-1:0] res_height
);

  localparam int C    = COORD_BITS;
  localparam int NUMW = 3 * C + 5;
  localparam int DW   = 2 * C + 2;
  localparam int QB   = C + 1;
  localparam int HW   = QB + 2;
  localparam int OW   = thxz_pkg::PORT_COORD_W;

  localparam logic signed [HW-1:0] H_MAX = signed'({{(HW-C+1){1'b0}}, {(C-1){1'b1}}});
  localparam logic signed [HW-1:0] H_MIN = signed'({{(HW-C+1){1'b1}}, {(C-1){1'b0}}});

  thxz_pkg::ctl_t      ctl_r [0:QB];
  logic [NUMW-1:0]     rem_r [0:QB];
  logic [QB-1:0]       q_r   [0:QB];
  logic [DW-1:0]       den_r [0:QB];
  logic                neg_r [0:QB];
  logic                ovf_r [0:QB];
  logic signed [C-1:0] ay_r  [0:QB];

  // Stage 0: a quotient of 2^QB or more saturates either way, so it is flagged.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else if (adv) begin
      ctl_r[0] <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= num_abs;
      q_r[0]   <= '0;
      den_r[0] <= den;
      neg_r[0] <= num_neg;
      ovf_r[0] <= num_abs >= (NUMW'(den) << QB);
      ay_r[0]  <= ay;
    end
  end

  for (genvar j = 0; j < QB; j++) begin : g_step
    logic [NUMW-1:0] sh;
    logic            ge;
    logic [NUMW-1:0] rem_nxt;
    logic [QB-1:0]   q_nxt;

    always_comb begin
      sh      = NUMW'(den_r[j]) << (QB - 1 - j);
      ge      = rem_r[j] >= sh;
      rem_nxt = ge ? (rem_r[j] - sh) : rem_r[j];
      q_nxt   = q_r[j] | (QB'(ge) << (QB - 1 - j));
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[j+1] <= '0;
      end else if (adv) begin
        ctl_r[j+1] <= ctl_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[j+1] <= rem_nxt;
        q_r[j+1]   <= q_nxt;
        den_r[j+1] <= den_r[j];
        neg_r[j+1] <= neg_r[j];
        ovf_r[j+1] <= ovf_r[j];
        ay_r[j+1]  <= ay_r[j];
      end
    end
  end

  // Rounding stage: ties go away from zero since the magnitude is rounded.
  thxz_pkg::ctl_t      rc_r;
  logic [QB:0]         qr_r, qr_nxt;
  logic                rneg_r;
  logic signed [C-1:0] ray_r;
  logic [DW:0]         twice;

  always_comb begin
    twice = {rem_r[QB][DW-1:0], 1'b0};
    if (ovf_r[QB]) begin
      qr_nxt = (QB+1)'(1) << QB;
    end else begin
      qr_nxt = {1'b0, q_r[QB]} + (QB+1)'(twice >= {1'b0, den_r[QB]});
    end
  end

  // Output stage.
  thxz_pkg::ctl_t        oc_r;
  logic                  oin_r, oin_nxt;
  logic signed [OW-1:0]  oh_r, oh_nxt;
  logic signed [HW-1:0]  hq, hsum, hsat;

  always_comb begin
    hq = HW'(signed'({1'b0, qr_r}));
    if (rneg_r) begin
      hq = -hq;
    end
    hsum = hq + HW'(ray_r);
    if (hsum > H_MAX) begin
      hsat = H_MAX;
    end else if (hsum < H_MIN) begin
      hsat = H_MIN;
    end else begin
      hsat = hsum;
    end
    oin_nxt = !rc_r.kill;
    oh_nxt  = rc_r.kill ? '0 : OW'(signed'(hsat[C-1:0]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r <= '0;
      oc_r <= '0;
    end else if (adv) begin
      rc_r <= ctl_r[QB];
      oc_r <= rc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      qr_r   <= qr_nxt;
      rneg_r <= neg_r[QB];
      ray_r  <= ay_r[QB];
      oin_r  <= oin_nxt;
      oh_r   <= oh_nxt;
    end
  end

  assign res_ctl    = oc_r;
  assign res_inside = oin_r;
  assign res_height = oh_r;

endmodule

// File: src/triangle_height_from_xz.sv
// ----------------------------------------------------------------------------
// triangle_height_from_xz: height on a triangle at a point given in x and z
// Vertex store plus a fully pipelined barycentric interpolator in Q16.16.
// ----------------------------------------------------------------------------
// The block accepts one beat per clock on the input channel. A write beat
// stores one vertex and produces no result. A query beat produces exactly one
// result beat. The three corners are read from the vertex store into its
// read registers, the geometry stages form edge vectors, cross products, the
// tolerance test and the height numerator, and then a divider resolves one
// quotient bit per stage, followed by rounding and the saturated output
// register. The whole pipeline advances together, so when the result channel
// is stalled the input stops taking beats and nothing is lost or repeated;
// with the result channel always ready the sustained rate is one beat per
// cycle. A vertex written by one beat is visible to a query in the very next
// beat. Reading a store entry that was never written returns arbitrary data.
module triangle_height_from_xz #(
  parameter int VERTEX_DEPTH = 256,
  parameter int COORD_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  thxz_in_if.sink           in_ch,
  thxz_out_if.source        out_ch
);

  localparam int C    = COORD_BITS;
  localparam int AW   = $clog2(VERTEX_DEPTH);
  localparam int SW   = thxz_pkg::SLOT_W;
  localparam int NUMW = 3 * C + 5;
  localparam int DW   = 2 * C + 2;

  // Global advance: the output register is empty or being drained.
  logic adv;
  logic out_valid;

  assign adv         = !out_valid || out_ch.ready;
  assign in_ch.ready = adv;

  // Corner selection: idx_c is the start of the other edge unless that
  // vertex is already idx_a or idx_b, and then it is that edge's end.
  logic [SW-1:0]  idx_a, idx_b, idx_c;
  logic           idx_bad;
  logic           slot_ok;
  logic           we;
  thxz_pkg::ctl_t p1_ctl_nxt, p1_ctl_r;

  always_comb begin
    idx_a = in_ch.first_edge_start;
    idx_b = in_ch.first_edge_end;
    idx_c = in_ch.second_edge_start;
    if (idx_c == idx_a || idx_c == idx_b) begin
      idx_c = in_ch.second_edge_end;
    end
    idx_bad = ({1'b0, idx_a} >= (SW+1)'(VERTEX_DEPTH)) ||
              ({1'b0, idx_b} >= (SW+1)'(VERTEX_DEPTH)) ||
              ({1'b0, idx_c} >= (SW+1)'(VERTEX_DEPTH));
    slot_ok = {1'b0, in_ch.vertex_slot} < (SW+1)'(VERTEX_DEPTH);
    we      = in_ch.valid && adv && (in_ch.mode == thxz_pkg::MODE_WRITE) && slot_ok;
    p1_ctl_nxt.valid = in_ch.valid && (in_ch.mode == thxz_pkg::MODE_QUERY);
    p1_ctl_nxt.kill  = idx_bad;
  end

  logic [3*C-1:0] rd_a, rd_b, rd_c;

  thxz_vstore #(
    .VERTEX_DEPTH (VERTEX_DEPTH),
    .COORD_BITS   (COORD_BITS)
  ) u_vstore (
    .clk     (clk),
    .adv     (adv),
    .we      (we),
    .waddr   (in_ch.vertex_slot[AW-1:0]),
    .wdata   ({in_ch.vertex_x[C-1:0], in_ch.vertex_y[C-1:0], in_ch.vertex_z[C-1:0]}),
    .raddr_a (idx_a[AW-1:0]),
    .raddr_b (idx_b[AW-1:0]),
    .raddr_c (idx_c[AW-1:0]),
    .rdata_a (rd_a),
    .rdata_b (rd_b),
    .rdata_c (rd_c)
  );

  // Side-band that lines up with the store's registered read data.
  logic signed [C-1:0] p1_qx_r, p1_qz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_ctl_r <= '0;
    end else if (adv) begin
      p1_ctl_r <= p1_ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_qx_r <= in_ch.query_x[C-1:0];
      p1_qz_r <= in_ch.query_z[C-1:0];
    end
  end

  thxz_pkg::ctl_t      g_ctl;
  logic [NUMW-1:0]     g_num;
  logic                g_neg;
  logic [DW-1:0]       g_den;
  logic signed [C-1:0] g_ay;

  thxz_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_ctl  (p1_ctl_r),
    .ax      (signed'(rd_a[3*C-1:2*C])),
    .ay      (signed'(rd_a[2*C-1:C])),
    .az      (signed'(rd_a[C-1:0])),
    .bx      (signed'(rd_b[3*C-1:2*C])),
    .by      (signed'(rd_b[2*C-1:C])),
    .bz      (signed'(rd_b[C-1:0])),
    .cx      (signed'(rd_c[3*C-1:2*C])),
    .cy      (signed'(rd_c[2*C-1:C])),
    .cz      (signed'(rd_c[C-1:0])),
    .qx      (p1_qx_r),
    .qz      (p1_qz_r),
    .out_ctl (g_ctl),
    .num_abs (g_num),
    .num_neg (g_neg),
    .den     (g_den),
    .ay_out  (g_ay)
  );

  thxz_pkg::ctl_t res_ctl;

  thxz_div #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_ctl     (g_ctl),
    .num_abs    (g_num),
    .num_neg    (g_neg),
    .den        (g_den),
    .ay         (g_ay),
    .res_ctl    (res_ctl),
    .res_inside (out_ch.inside_res),
    .res_height (out_ch.height)
  );

  assign out_valid    = res_ctl.valid;
  assign out_ch.valid = out_valid;

endmodule

// File: test/triangle_height_from_xz_test.sv
// ----------------------------------------------------------------------------
// triangle_height_from_xz_test: self-checking testbench for the height block
// Loads vertices, sends height queries and compares each result beat with a
// Q16.16 barycentric predictor kept inside the bench, under random idling on
// both channels.
// ----------------------------------------------------------------------------
module triangle_height_from_xz_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH       = 256;
  localparam int SW          = thxz_pkg::SLOT_W;
  // Drain time after the last beat, with margin over the pipeline depth.
  localparam int DRAIN_WAIT  = 80;
  // No beat on either side for this many cycles means the block is stuck.
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [127:0]                       wide_t;
  typedef logic signed [thxz_pkg::PORT_COORD_W-1:0]  coord_t;

  typedef struct {
    logic          mode;
    logic [SW-1:0] slot;
    coord_t        vx, vy, vz;
    logic [SW-1:0] fes, fee, ses, see;
    coord_t        qx, qz;
  } beat_t;

  typedef struct {
    logic   hit;
    coord_t height;
  } height_t;

  logic clk;
  logic rst_n;

  thxz_in_if  in_ch ();
  thxz_out_if out_ch ();

  triangle_height_from_xz dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bench copy of the vertex store, plus which slots hold real data.
  coord_t  store_x [DEPTH];
  coord_t  store_y [DEPTH];
  coord_t  store_z [DEPTH];
  bit      loaded  [DEPTH];
  int      loaded_slots [$];

  height_t pending_heights [$];
  bit      failed;
  int      tx_idle_pct;
  int      rx_idle_pct;
  int      stall_cycles;
  int      n_writes, n_queries, n_inside, n_checked;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // The receiver's ready is redrawn on every edge from the current idle rate.
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Work out the result of one query from the bench's own store.
  function automatic height_t predict_height(beat_t b);
    height_t res;
    int    ca, cb, cc;
    wide_t e0x, e0z, e1x, e1z, e2x, e2z, e1y, e2y;
    wide_t den, ns, nt, dk1, kk, num, mag, quo, rem, h;
    bit    neg;
    res.hit    = 1'b0;
    res.height = '0;
    ca = int'(b.fes);
    cb = int'(b.fee);
    cc = int'(b.ses);
    // The third corner falls back to the far end when the near end is shared.
    if (cc == ca || cc == cb) cc = int'(b.see);
    e1x = wide_t'(store_x[cb]) - wide_t'(store_x[ca]);
    e1z = wide_t'(store_z[cb]) - wide_t'(store_z[ca]);
    e2x = wide_t'(store_x[cc]) - wide_t'(store_x[ca]);
    e2z = wide_t'(store_z[cc]) - wide_t'(store_z[ca]);
    e0x = wide_t'(b.qx) - wide_t'(store_x[ca]);
    e0z = wide_t'(b.qz) - wide_t'(store_z[ca]);
    den = e1x * e2z - e1z * e2x;
    if (den == 0) return res;
    ns = e0x * e2z - e0z * e2x;
    nt = e1x * e0z - e1z * e0x;
    if (den < 0) begin
      den = -den;
      ns  = -ns;
      nt  = -nt;
    end
    kk  = wide_t'(thxz_pkg::TOL_K);
    dk1 = den * wide_t'(thxz_pkg::TOL_K1);
    // Tolerance test done exactly on integers: s, t >= -1e-5 and s, t,
    // s + t <= 1 + 1e-5.
    if (kk * ns + den < 0 || kk * nt + den < 0) return res;
    if (dk1 < kk * ns || dk1 < kk * nt || dk1 < kk * (ns + nt)) return res;
    e1y = wide_t'(store_y[cb]) - wide_t'(store_y[ca]);
    e2y = wide_t'(store_y[cc]) - wide_t'(store_y[ca]);
    num = ns * e1y + nt * e2y;
    neg = (num < 0);
    mag = neg ? -num : num;
    quo = mag / den;
    rem = mag % den;
    // Round to nearest with ties away from zero.
    if (2 * rem >= den) quo = quo + 1;
    if (quo > (wide_t'(1) <<< 62)) quo = wide_t'(1) <<< 62;
    h = neg ? -quo : quo;
    h = h + wide_t'(store_y[ca]);
    if (h > wide_t'(32'sh7fffffff)) h = wide_t'(32'sh7fffffff);
    if (h < -wide_t'(64'sh80000000)) h = -wide_t'(64'sh80000000);
    res.hit    = 1'b1;
    res.height = h[31:0];
    return res;
  endfunction

  // Offer one beat, wait for the handshake, then update the bench model.
  task automatic send_beat(beat_t b);
    height_t res;
    in_ch.valid             <= 1'b1;
    in_ch.mode              <= b.mode;
    in_ch.vertex_slot       <= b.slot;
    in_ch.vertex_x          <= b.vx;
    in_ch.vertex_y          <= b.vy;
    in_ch.vertex_z          <= b.vz;
    in_ch.first_edge_start  <= b.fes;
    in_ch.first_edge_end    <= b.fee;
    in_ch.second_edge_start <= b.ses;
    in_ch.second_edge_end   <= b.see;
    in_ch.query_x           <= b.qx;
    in_ch.query_z           <= b.qz;
    do @(posedge clk); while (!in_ch.ready);
    if (b.mode == thxz_pkg::MODE_WRITE) begin
      store_x[b.slot] = b.vx;
      store_y[b.slot] = b.vy;
      store_z[b.slot] = b.vz;
      if (!loaded[b.slot]) loaded_slots.push_back(int'(b.slot));
      loaded[b.slot] = 1'b1;
      n_writes++;
    end else begin
      res = predict_height(b);
      pending_heights.push_back(res);
      n_queries++;
      if (res.hit) n_inside++;
    end
    // Valid is only dropped when a gap is actually taken, so consecutive
    // beats never see a lower-then-raise within one edge. Idle cycles are
    // drawn one at a time so the idle share follows the rate.
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
  endtask

  function automatic beat_t vertex_beat(int slot, coord_t x, coord_t y, coord_t z);
    beat_t b;
    b = '{default: '0};
    b.mode = thxz_pkg::MODE_WRITE;
    b.slot = SW'(slot);
    b.vx = x;
    b.vy = y;
    b.vz = z;
    // Query fields carry noise on write beats; the block must ignore them.
    b.fes = SW'($urandom);
    b.qx  = $urandom;
    return b;
  endfunction

  function automatic beat_t query_beat(int a, int bb, int c, int d, coord_t x, coord_t z);
    beat_t b;
    b = '{default: '0};
    b.mode = thxz_pkg::MODE_QUERY;
    b.fes = SW'(a);
    b.fee = SW'(bb);
    b.ses = SW'(c);
    b.see = SW'(d);
    b.qx = x;
    b.qz = z;
    b.slot = SW'($urandom);
    b.vy = $urandom;
    return b;
  endfunction

  // Pause the sender until every outstanding query has been answered.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_heights.size() != 0);
  endtask

  task automatic test_directed();
    // A unit right triangle with heights 0, 2 and -1, a collinear point,
    // and corners at the extremes of the coordinate range.
    send_beat(vertex_beat(0, 32'sh0, 32'sh0, 32'sh0));
    send_beat(vertex_beat(1, 32'sh10000, 32'sh20000, 32'sh0));
    send_beat(vertex_beat(2, 32'sh0, -32'sh10000, 32'sh10000));
    send_beat(vertex_beat(3, 32'sh20000, 32'sh7fffffff, 32'sh0));
    send_beat(vertex_beat(255, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
    send_beat(vertex_beat(254, 32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    send_beat(vertex_beat(128, 32'sh7fffffff, 32'sh80000000, 32'sh80000000));
    // Point inside, then a corner exactly, then a point on an edge.
    send_beat(query_beat(0, 1, 2, 3, 32'sh4000, 32'sh4000));
    send_beat(query_beat(0, 1, 2, 3, 32'sh10000, 32'sh0));
    send_beat(query_beat(0, 1, 2, 3, 32'sh8000, 32'sh8000));
    // Points just beyond the tolerance, then one far outside.
    send_beat(query_beat(0, 1, 2, 3, -32'sh1, 32'sh8000));
    send_beat(query_beat(0, 1, 2, 3, -32'sh100, 32'sh8000));
    send_beat(query_beat(0, 1, 2, 3, 32'sh7fffffff, 32'sh80000000));
    // Degenerate triangles: three collinear corners, and a repeated corner.
    send_beat(query_beat(0, 1, 3, 2, 32'sh4000, 32'sh0));
    send_beat(query_beat(0, 0, 1, 2, 32'sh0, 32'sh0));
    // The near end of the other edge is shared, so its far end is the corner.
    send_beat(query_beat(0, 1, 1, 2, 32'sh2000, 32'sh2000));
    send_beat(query_beat(0, 1, 0, 2, 32'sh2000, 32'sh2000));
    // Huge triangles spanning the whole range, then a small one with a corner at the top height.
    send_beat(query_beat(255, 254, 128, 0, 32'sh0, 32'sh0));
    send_beat(query_beat(128, 255, 254, 1, 32'sh7fff0000, 32'sh7fff0000));
    send_beat(query_beat(3, 1, 2, 0, 32'sh10000, 32'sh100));
    wait_for_drain();
  endtask

  function automatic coord_t rand_coord();
    if ($urandom_range(99) < 20) return $urandom;
    return $signed($urandom_range(0, 32'h1fffff)) - 32'sh100000;
  endfunction

  function automatic int rand_loaded();
    return loaded_slots[$urandom_range(loaded_slots.size() - 1)];
  endfunction

  // Mostly queries aimed in and around triangles made of loaded vertices,
  // with a share of fresh writes and of points thrown anywhere.
  task automatic test_random(int count, int tx_pct, int rx_pct);
    beat_t  b;
    int     a, c, d, e;
    longint px, pz, u, v;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (count) begin
      if ($urandom_range(99) < 30) begin
        b = vertex_beat($urandom_range(255), rand_coord(), $urandom, rand_coord());
      end else begin
        a = rand_loaded();
        c = rand_loaded();
        d = rand_loaded();
        e = rand_loaded();
        if ($urandom_range(99) < 20) begin
          d = ($urandom_range(1)) ? a : c;
        end
        b = query_beat(a, c, d, e, 0, 0);
        if (d == a || d == c) d = e;
        if ($urandom_range(99) < 20) begin
          b.qx = $urandom;
          b.qz = $urandom;
        end else begin
          u = longint'($urandom_range(0, 1100));
          v = longint'($urandom_range(0, 1100 - u));
          px = longint'(store_x[a])
             + ((longint'(store_x[c]) - store_x[a]) * u
             + (longint'(store_x[d]) - store_x[a]) * v) / 1024;
          pz = longint'(store_z[a])
             + ((longint'(store_z[c]) - store_z[a]) * u
             + (longint'(store_z[d]) - store_z[a]) * v) / 1024;
          b.qx = px[31:0];
          b.qz = pz[31:0];
        end
      end
      send_beat(b);
    end
    wait_for_drain();
  endtask

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_heights.size() == 0) begin
        $error("result beat with no query outstanding");
        failed = 1'b1;
      end else begin
        height_t want;
        want = pending_heights.pop_front();
        n_checked++;
        if (out_ch.inside_res !== want.hit) begin
          $error("inside_res mismatch: expected %0d actual %0d", want.hit,
                 out_ch.inside_res);
          failed = 1'b1;
        end
        if (out_ch.height !== want.height) begin
          $error("height mismatch: expected %0d actual %0d", want.height,
                 out_ch.height);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog: counts edges with no beat moving on either channel.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("triangle_height_from_xz_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    failed       = 1'b0;
    stall_cycles = 0;
    n_writes     = 0;
    n_queries    = 0;
    n_inside     = 0;
    n_checked    = 0;
    tx_idle_pct  = 0;
    rx_idle_pct  = 0;
    rst_n        = 1'b0;
    out_ch.ready = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.mode   = thxz_pkg::MODE_QUERY;
    in_ch.vertex_slot       = '0;
    in_ch.vertex_x          = '0;
    in_ch.vertex_y          = '0;
    in_ch.vertex_z          = '0;
    in_ch.first_edge_start  = '0;
    in_ch.first_edge_end    = '0;
    in_ch.second_edge_start = '0;
    in_ch.second_edge_end   = '0;
    in_ch.query_x           = '0;
    in_ch.query_z           = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(330, 25, 45);
    test_random(330, 45, 25);
    test_random(340, 0, 0);

    in_ch.valid <= 1'b0;
    repeat (DRAIN_WAIT) @(posedge clk);
    if (pending_heights.size() != 0) begin
      $error("%0d expected results never arrived", pending_heights.size());
      failed = 1'b1;
    end
    $display("covered %0d vertex writes and %0d queries (%0d inside), %0d results checked",
             n_writes, n_queries, n_inside, n_checked);
    if (!failed) begin
      $display("triangle_height_from_xz_test: PASS");
    end else begin
      $display("triangle_height_from_xz_test: FAIL");
    end
    $finish;
  end

endmodule

// File: triangle_height_from_xz.f
src/thxz_pkg.sv
src/thxz_in_if.sv
src/thxz_out_if.sv
src/thxz_vstore.sv
src/thxz_geom.sv
src/thxz_div.sv
src/triangle_height_from_xz.sv
test/triangle_height_from_xz_test.sv
